// ===== sv/gnta_pkg.sv =====
// Shared types, constants and codes for the greedy nearest track association unit.
package gnta_pkg;

    localparam int MAX_TRACKS = 16;
    localparam int COORD_BITS = 16;
    localparam int ID_BITS    = 16;

    localparam int IDX_BITS   = $clog2(MAX_TRACKS);
    localparam int LIVE_BITS  = $clog2(MAX_TRACKS + 1);
    localparam int CNT_BITS   = $clog2(MAX_TRACKS + 2);
    localparam int MISS_BITS  = 5;
    localparam int THR_BITS   = 34;
    localparam int MAXM_BITS  = 4;
    localparam int ABS_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * ABS_BITS;
    localparam int DIST_BITS  = SQ_BITS + 1;
    localparam int CMP_BITS   = (DIST_BITS > THR_BITS) ? DIST_BITS : THR_BITS;
    localparam int CFG_BITS   = 34;
    localparam int NUM_BITS   = 16;

    localparam logic [MISS_BITS-1:0] MISS_SAT      = MISS_BITS'(31);
    localparam logic [THR_BITS-1:0]  THRESH_RESET  = THR_BITS'(1000);
    localparam logic [MAXM_BITS-1:0] MAXMISS_RESET = MAXM_BITS'(3);

    localparam logic REG_DIST_THRESHOLD = 1'b0;
    localparam logic REG_MAX_MISSED     = 1'b1;

    localparam logic REQ_DETECTION = 1'b0;
    localparam logic REQ_END_FRAME = 1'b1;

    typedef enum logic [2:0] {
        EV_MATCHED = 3'd0,
        EV_CREATED = 3'd1,
        EV_FULL    = 3'd2,
        EV_DELETED = 3'd3,
        EV_DONE    = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE,
        CELL_LOAD,
        CELL_AGE
    } t_cell_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_AGE,
        ST_DEL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [ID_BITS-1:0]           id;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [MISS_BITS-1:0]         misses;
        logic                         used;
    } t_entry;

    typedef struct packed {
        logic                ok;
        logic [IDX_BITS-1:0] idx;
    } t_tag;

endpackage

// ===== sv/gnta_cell.sv =====
// One table cell: holds a track entry, loads or ages it, or takes its neighbor's entry on request.
module gnta_cell (
    input  logic              i_clk,
    input  gnta_pkg::t_cell_op i_op,
    input  gnta_pkg::t_entry  i_nbr,
    input  gnta_pkg::t_entry  i_load,
    output gnta_pkg::t_entry  o_entry
);
    import gnta_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_op)
            CELL_HOLD: n_entry = r_entry;
            CELL_TAKE: n_entry = i_nbr;
            CELL_LOAD: n_entry = i_load;
            CELL_AGE: begin
                if (r_entry.used) begin
                    n_entry.misses = '0;
                end else if (r_entry.misses != MISS_SAT) begin
                    n_entry.misses = r_entry.misses + MISS_BITS'(1);
                end
                n_entry.used = 1'b0;
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== sv/gnta_dist.sv =====
// Two-stage squared distance unit fed from the head cell of the table.
module gnta_dist (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic signed [gnta_pkg::COORD_BITS-1:0] i_det_x,
    input  logic signed [gnta_pkg::COORD_BITS-1:0] i_det_y,
    input  logic signed [gnta_pkg::COORD_BITS-1:0] i_trk_x,
    input  logic signed [gnta_pkg::COORD_BITS-1:0] i_trk_y,
    input  gnta_pkg::t_tag                         i_tag,
    output logic [gnta_pkg::DIST_BITS-1:0]         o_dist,
    output gnta_pkg::t_tag                         o_tag
);
    import gnta_pkg::*;

    logic signed [ABS_BITS-1:0] w_dx;
    logic signed [ABS_BITS-1:0] w_dy;
    logic [ABS_BITS-1:0]        w_ax;
    logic [ABS_BITS-1:0]        w_ay;
    logic [SQ_BITS-1:0]         r_sq_x;
    logic [SQ_BITS-1:0]         r_sq_y;
    logic [DIST_BITS-1:0]       r_dist;
    t_tag                       r_tag1;
    t_tag                       r_tag2;

    always_comb begin
        w_dx = ABS_BITS'(i_det_x) - ABS_BITS'(i_trk_x);
        w_dy = ABS_BITS'(i_det_y) - ABS_BITS'(i_trk_y);
        w_ax = w_dx[ABS_BITS-1] ? ABS_BITS'(-w_dx) : ABS_BITS'(w_dx);
        w_ay = w_dy[ABS_BITS-1] ? ABS_BITS'(-w_dy) : ABS_BITS'(w_dy);
    end

    always_ff @(posedge i_clk) begin
        r_sq_x <= SQ_BITS'(w_ax * w_ax);
        r_sq_y <= SQ_BITS'(w_ay * w_ay);
        r_dist <= DIST_BITS'(r_sq_x) + DIST_BITS'(r_sq_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    assign o_dist = r_dist;
    assign o_tag  = r_tag2;

endmodule

// ===== sv/greedy_nearest_track_association_unit.sv =====
// Top level: track table as a ring of cells, scan control, frame-end deletion and output.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_req_type, i_det_x, i_det_y
//  out     | output    | o_out_valid / i_out_stall| o_event_kind, o_track_number, o_last
//  cfg     | input     | i_cfg_we               | i_cfg_index, i_cfg_data
//
// After a detection transfer the input stalls while the table rotates once through the head
// cell, whose entry feeds a two-stage distance unit, then while the result is decided and
// written. After an end of frame it stalls to age the table, check each live entry for
// deletion and send done. Both stalls stretch while a result waits for the stalled output
// register to free up. Reset clears control, live count and id counter; table contents are
// undefined until written. A stalled output holds the finished result while the next item
// is transferred.
module greedy_nearest_track_association_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_req_type,
    input  logic signed [gnta_pkg::COORD_BITS-1:0] i_det_x,
    input  logic signed [gnta_pkg::COORD_BITS-1:0] i_det_y,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [2:0]                             o_event_kind,
    output logic [gnta_pkg::NUM_BITS-1:0]          o_track_number,
    output logic                                   o_last,
    input  logic                                   i_cfg_we,
    input  logic                                   i_cfg_index,
    input  logic [gnta_pkg::CFG_BITS-1:0]          i_cfg_data
);
    import gnta_pkg::*;

    // configuration registers
    logic [THR_BITS-1:0]  r_thresh;
    logic [MAXM_BITS-1:0] r_max_missed;

    // control
    t_state               r_state;
    t_state               n_state;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [CNT_BITS-1:0]  n_cnt;
    logic [LIVE_BITS-1:0] r_live;
    logic [LIVE_BITS-1:0] n_live;
    logic [ID_BITS-1:0]   r_id_ctr;
    logic [ID_BITS-1:0]   n_id_ctr;
    logic [IDX_BITS-1:0]  r_idx;
    logic [IDX_BITS-1:0]  n_idx;

    // detection under work and best match so far
    logic signed [COORD_BITS-1:0] r_det_x;
    logic signed [COORD_BITS-1:0] r_det_y;
    logic                         r_best_ok;
    logic                         n_best_ok;
    logic [IDX_BITS-1:0]          r_best_idx;
    logic [IDX_BITS-1:0]          n_best_idx;
    logic [DIST_BITS-1:0]         r_best_d;
    logic [DIST_BITS-1:0]         n_best_d;

    // output register
    logic                 r_out_valid;
    t_event               r_out_kind;
    logic [ID_BITS-1:0]   r_out_id;
    logic                 r_out_last;
    logic                 w_emit;
    t_event               w_emit_kind;
    logic [ID_BITS-1:0]   w_emit_id;
    logic                 w_emit_last;
    logic                 w_out_free;

    // cells
    t_entry               w_cell [MAX_TRACKS];
    t_cell_op             w_op   [MAX_TRACKS];
    t_entry               w_load;
    logic [IDX_BITS-1:0]  w_load_idx;
    logic                 w_load_en;

    t_tag                 w_tag_in;
    t_tag                 w_tag_out;
    logic [DIST_BITS-1:0] w_dist;

    logic                 w_accept;
    logic                 w_match;
    logic                 w_del_hit;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh     <= THRESH_RESET;
            r_max_missed <= MAXMISS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DIST_THRESHOLD: r_thresh     <= i_cfg_data[THR_BITS-1:0];
                REG_MAX_MISSED:     r_max_missed <= i_cfg_data[MAXM_BITS-1:0];
                default:            r_thresh     <= r_thresh;
            endcase
        end
    end

    // the ring of cells: each cell's neighbor is the next one, the last wraps to the head
    for (genvar g = 0; g < MAX_TRACKS; g++) begin : g_cell
        gnta_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op[g]),
            .i_nbr   (w_cell[(g == MAX_TRACKS - 1) ? 0 : g + 1]),
            .i_load  (w_load),
            .o_entry (w_cell[g])
        );
    end

    // the head cell feeds the distance unit; the tag says which entry it was and if it counts
    always_comb begin
        w_tag_in.idx = r_cnt[IDX_BITS-1:0];
        w_tag_in.ok  = (r_state == ST_SCAN) && (r_cnt < CNT_BITS'(MAX_TRACKS))
                       && (LIVE_BITS'(r_cnt) < r_live) && !w_cell[0].used;
    end

    gnta_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_det_x (r_det_x),
        .i_det_y (r_det_y),
        .i_trk_x (w_cell[0].x),
        .i_trk_y (w_cell[0].y),
        .i_tag   (w_tag_in),
        .o_dist  (w_dist),
        .o_tag   (w_tag_out)
    );

    assign w_match   = r_best_ok && (CMP_BITS'(r_best_d) < CMP_BITS'(r_thresh));
    assign w_del_hit = w_cell[r_idx].misses > MISS_BITS'(r_max_missed);

    // next state, cell operations and results
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_live      = r_live;
        n_id_ctr    = r_id_ctr;
        n_idx       = r_idx;
        n_best_ok   = r_best_ok;
        n_best_idx  = r_best_idx;
        n_best_d    = r_best_d;
        w_emit      = 1'b0;
        w_emit_kind = EV_DONE;
        w_emit_id   = '0;
        w_emit_last = 1'b0;
        w_load_en   = 1'b0;
        w_load_idx  = '0;
        w_load.id     = r_id_ctr;
        w_load.x      = r_det_x;
        w_load.y      = r_det_y;
        w_load.misses = '0;
        w_load.used   = 1'b1;
        for (int c = 0; c < MAX_TRACKS; c++) begin
            w_op[c] = CELL_HOLD;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cnt     = '0;
                    n_best_ok = 1'b0;
                    n_state   = (i_req_type == REQ_END_FRAME) ? ST_AGE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // rotate the whole ring one place while entries pass the head
                if (r_cnt < CNT_BITS'(MAX_TRACKS)) begin
                    for (int c = 0; c < MAX_TRACKS; c++) begin
                        w_op[c] = CELL_TAKE;
                    end
                end
                // strict less keeps the earliest track on a tie
                if (w_tag_out.ok && (!r_best_ok || w_dist < r_best_d)) begin
                    n_best_ok  = 1'b1;
                    n_best_idx = w_tag_out.idx;
                    n_best_d   = w_dist;
                end
                if (r_cnt == CNT_BITS'(MAX_TRACKS + 1)) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_cnt = r_cnt + CNT_BITS'(1);
                end
            end
            ST_DECIDE: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_last = 1'b1;
                    n_state     = ST_IDLE;
                    if (w_match) begin
                        w_load_en   = 1'b1;
                        w_load_idx  = r_best_idx;
                        w_load.id   = w_cell[r_best_idx].id;
                        w_emit_kind = EV_MATCHED;
                        w_emit_id   = w_cell[r_best_idx].id;
                    end else if (r_live < LIVE_BITS'(MAX_TRACKS)) begin
                        w_load_en   = 1'b1;
                        w_load_idx  = r_live[IDX_BITS-1:0];
                        w_emit_kind = EV_CREATED;
                        w_emit_id   = r_id_ctr;
                        n_live      = r_live + LIVE_BITS'(1);
                        n_id_ctr    = r_id_ctr + ID_BITS'(1);
                    end else begin
                        w_emit_kind = EV_FULL;
                    end
                end
            end
            ST_AGE: begin
                for (int c = 0; c < MAX_TRACKS; c++) begin
                    w_op[c] = CELL_AGE;
                end
                if (r_live == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx   = IDX_BITS'(r_live - LIVE_BITS'(1));
                    n_state = ST_DEL;
                end
            end
            ST_DEL: begin
                // walk from the back; a deleted entry closes up by shifting the tail down
                if (w_del_hit && !w_out_free) begin
                    n_state = ST_DEL;
                end else begin
                    if (w_del_hit) begin
                        w_emit      = 1'b1;
                        w_emit_kind = EV_DELETED;
                        w_emit_id   = w_cell[r_idx].id;
                        n_live      = r_live - LIVE_BITS'(1);
                        for (int c = 0; c < MAX_TRACKS; c++) begin
                            if (IDX_BITS'(c) >= r_idx) begin
                                w_op[c] = CELL_TAKE;
                            end
                        end
                    end
                    if (r_idx == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_idx = r_idx - IDX_BITS'(1);
                    end
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_kind = EV_DONE;
                    w_emit_last = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (w_load_en) begin
            w_op[w_load_idx] = CELL_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_live      <= '0;
            r_id_ctr    <= '0;
            r_idx       <= '0;
            r_best_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_live    <= n_live;
            r_id_ctr  <= n_id_ctr;
            r_idx     <= n_idx;
            r_best_ok <= n_best_ok;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_det_x <= i_det_x;
            r_det_y <= i_det_y;
        end
        r_best_idx <= n_best_idx;
        r_best_d   <= n_best_d;
        if (w_emit) begin
            r_out_kind <= w_emit_kind;
            r_out_id   <= w_emit_id;
            r_out_last <= w_emit_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_out_kind;
    assign o_track_number = NUM_BITS'(r_out_id);
    assign o_last         = r_out_last;

`ifndef ASSERT_OFF
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= LIVE_BITS'(MAX_TRACKS))
        else $error("live count beyond table size");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_emit)
        else $error("result overwritten while stalled");

    a_best_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE && r_best_ok) |-> (LIVE_BITS'(r_best_idx) < r_live))
        else $error("best match outside live tracks");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == EV_DONE) |-> r_out_last)
        else $error("frame done without last");

    a_del_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_emit_kind == EV_DELETED) |-> !w_emit_last)
        else $error("deletion marked last");
`endif

endmodule
